[rtl/srtc_pkg.sv]
// Shared types, constants and table functions for the segment rotate/translate/clamp block.
package srtc_pkg;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int PIPE_DEPTH = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [8:0] WIDTH_RESET  = 9'd128;
	localparam logic [8:0] HEIGHT_RESET = 9'd64;
	localparam logic [8:0] SCREEN_MAX   = 9'd256;

	localparam logic [8:0] FULL_TURN    = 9'd360;
	localparam logic [8:0] HALF_TURN    = 9'd180;
	localparam logic [8:0] QUARTER_TURN = 9'd90;
	localparam logic [8:0] COS_WRAP     = 9'd450;

	// 46 full turns: moves any 15-bit angle onto a positive range
	localparam logic signed [16:0] ANGLE_BIAS = 17'sd16560;
	// floor(2^23 / 360): quotient estimate is low by at most one
	localparam logic [31:0] TURN_RECIP = 32'd23301;
	localparam int          TURN_SHIFT = 23;
	// x / 5 == (x * 205) >> 10 for x up to 90
	localparam logic [14:0] FIFTH_RECIP = 15'd205;

	typedef struct packed {
		logic signed [14:0] centre_x;
		logic signed [14:0] centre_y;
		logic signed [7:0]  start_px;
		logic signed [7:0]  start_py;
		logic signed [7:0]  end_px;
		logic signed [7:0]  end_py;
	} geom_t;

	typedef struct packed {
		geom_t              geom;
		logic signed [14:0] angle_deg;
	} stage1_t;

	typedef struct packed {
		geom_t       geom;
		logic [15:0] angle_pos;
		logic [6:0]  turns;
	} stage2_t;

	typedef struct packed {
		geom_t             geom;
		logic signed [8:0] sin_v;
		logic signed [8:0] cos_v;
	} stage3_t;

	typedef struct packed {
		logic signed [16:0] xc;
		logic signed [16:0] ys;
		logic signed [16:0] xs;
		logic signed [16:0] yc;
	} prod_t;

	typedef struct packed {
		logic signed [14:0] centre_x;
		logic signed [14:0] centre_y;
		prod_t              p0;
		prod_t              p1;
	} stage4_t;

	typedef struct packed {
		logic [7:0] screen_y1;
		logic [7:0] screen_x1;
		logic [7:0] screen_y0;
		logic [7:0] screen_x0;
	} result_t;

	function automatic logic [7:0] sine_mag(input logic [4:0] idx);
		logic [7:0] m;
		case (idx)
			5'd0:    m = 8'd1;
			5'd1:    m = 8'd11;
			5'd2:    m = 8'd22;
			5'd3:    m = 8'd33;
			5'd4:    m = 8'd44;
			5'd5:    m = 8'd55;
			5'd6:    m = 8'd64;
			5'd7:    m = 8'd73;
			5'd8:    m = 8'd81;
			5'd9:    m = 8'd88;
			5'd10:   m = 8'd94;
			5'd11:   m = 8'd100;
			5'd12:   m = 8'd104;
			5'd13:   m = 8'd108;
			5'd14:   m = 8'd112;
			5'd15:   m = 8'd116;
			5'd16:   m = 8'd120;
			5'd17:   m = 8'd124;
			default: m = 8'd128;
		endcase
		return m;
	endfunction

	// r is an angle in 0..359; returns the table sine scaled by 128
	function automatic logic signed [8:0] fold_sine(input logic [8:0] r);
		logic        neg;
		logic [8:0]  a;
		logic [14:0] scaled;
		logic [8:0]  mag;
		neg = r > HALF_TURN;
		a   = neg ? FULL_TURN - r : r;
		if (a > QUARTER_TURN)
			a = HALF_TURN - a;
		scaled = {8'd0, a[6:0]} * FIFTH_RECIP;
		mag    = {1'b0, sine_mag(scaled[14:10])};
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

[rtl/segment_rotate_translate_clamp_top.sv]
// Top level: stream pipeline that rotates a sprite segment and places it on the screen.
//
// Input stream (s_axis_*): one transfer carries a centre point, two sprite endpoints
// in a y-up frame and an angle in degrees. Output stream (m_axis_*): one transfer per
// input with the four clamped screen coordinates of the segment.
// Configuration: wr_en/wr_index/wr_data write screen_width (index 0) and screen_height
// (index 1); write them only while no item is in flight.
//
// Each item passes in order through five registered stages, and its result is offered
// as soon as it is held in the last of them. Throughput: one item per cycle while the
// receiver does not stall. The stages are input capture, the reciprocal multiply that
// reduces the angle, the sine/cosine table, the rotation multipliers, and the
// translate/clamp output register.
//
// Reset clears all stage valid flags and sets the screen to 128 by 64.
// When the receiver stalls, the output register holds its result and the stages
// behind it keep filling empty slots; s_axis_tready falls only once every stage
// holds an item.
module segment_rotate_translate_clamp_top
	import srtc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// centre_x[14:0], centre_y[29:15], start_px[37:30], start_py[45:38],
	// end_px[53:46], end_py[61:54], angle_deg[76:62], zero[79:77]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// screen_x0[7:0], screen_y0[15:8], screen_x1[23:16], screen_y1[31:24]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [8:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SCREEN_WIDTH:  width_q  <= wr_data;
				REG_SCREEN_HEIGHT: height_q <= wr_data;
			endcase
		end
	end

	logic    vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic    en1, en2, en3, en4, en_out;
	stage1_t st_s1;
	stage2_t st_s2;
	stage3_t st_s3;
	stage4_t st_s4;
	result_t res_q;

	stage1_t in_item;
	logic [15:0]       angle_pos;
	logic [6:0]        turns;
	logic signed [8:0] sin_v, cos_v;
	prod_t             p0, p1;
	result_t           res;

	// a stage advances when it is empty or the one after it advances
	assign en_out = !out_vld_q || m_axis_tready;
	assign en4    = !vld_s4 || en_out;
	assign en3    = !vld_s3 || en4;
	assign en2    = !vld_s2 || en3;
	assign en1    = !vld_s1 || en2;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = res_q;

	assign in_item.geom.centre_x = s_axis_tdata[14:0];
	assign in_item.geom.centre_y = s_axis_tdata[29:15];
	assign in_item.geom.start_px = s_axis_tdata[37:30];
	assign in_item.geom.start_py = s_axis_tdata[45:38];
	assign in_item.geom.end_px   = s_axis_tdata[53:46];
	assign in_item.geom.end_py   = s_axis_tdata[61:54];
	assign in_item.angle_deg     = s_axis_tdata[76:62];

	srtc_angle_mod u_angle_mod (
		.angle_deg (st_s1.angle_deg),
		.angle_pos (angle_pos),
		.turns     (turns)
	);

	srtc_trig u_trig (
		.angle_pos (st_s2.angle_pos),
		.turns     (st_s2.turns),
		.sin_v     (sin_v),
		.cos_v     (cos_v)
	);

	srtc_rotate u_rotate (
		.geom  (st_s3.geom),
		.sin_v (st_s3.sin_v),
		.cos_v (st_s3.cos_v),
		.p0    (p0),
		.p1    (p1)
	);

	srtc_place u_place (
		.st            (st_s4),
		.screen_width  (width_q),
		.screen_height (height_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1)    vld_s1    <= s_axis_tvalid;
			if (en2)    vld_s2    <= vld_s1;
			if (en3)    vld_s3    <= vld_s2;
			if (en4)    vld_s4    <= vld_s3;
			if (en_out) out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid)
			st_s1 <= in_item;
		if (en2 && vld_s1) begin
			st_s2.geom      <= st_s1.geom;
			st_s2.angle_pos <= angle_pos;
			st_s2.turns     <= turns;
		end
		if (en3 && vld_s2) begin
			st_s3.geom  <= st_s2.geom;
			st_s3.sin_v <= sin_v;
			st_s3.cos_v <= cos_v;
		end
		if (en4 && vld_s3) begin
			st_s4.centre_x <= st_s3.geom.centre_x;
			st_s4.centre_y <= st_s3.geom.centre_y;
			st_s4.p0       <= p0;
			st_s4.p1       <= p1;
		end
		if (en_out && vld_s4)
			res_q <= res;
	end

endmodule

[rtl/srtc_angle_mod.sv]
// Angle bias and reciprocal multiply that estimates the number of full turns.
module srtc_angle_mod
	import srtc_pkg::*;
(
	input  logic signed [14:0] angle_deg,
	output logic [15:0]        angle_pos,
	output logic [6:0]         turns
);

	logic signed [16:0] biased;
	logic [31:0]        prod;

	assign biased    = 17'(angle_deg) + ANGLE_BIAS;
	assign angle_pos = biased[15:0];
	assign prod      = {16'd0, angle_pos} * TURN_RECIP;
	assign turns     = prod[TURN_SHIFT+6:TURN_SHIFT];

endmodule

[rtl/srtc_trig.sv]
// Remainder correction, quadrant fold and table lookup for sine and cosine.
module srtc_trig
	import srtc_pkg::*;
(
	input  logic [15:0]       angle_pos,
	input  logic [6:0]        turns,
	output logic signed [8:0] sin_v,
	output logic signed [8:0] cos_v
);

	logic [15:0] whole;
	logic [15:0] diff;
	logic [9:0]  rem_raw;
	logic [8:0]  rem;
	logic [8:0]  cos_ang;

	assign whole   = {9'd0, turns} * {7'd0, FULL_TURN};
	assign diff    = angle_pos - whole;
	assign rem_raw = diff[9:0];
	// estimate may be one turn short
	assign rem     = (rem_raw >= {1'b0, FULL_TURN}) ? 9'(rem_raw - {1'b0, FULL_TURN})
	                                                : rem_raw[8:0];
	// (90 - angle) mod 360
	assign cos_ang = (rem <= QUARTER_TURN) ? QUARTER_TURN - rem : COS_WRAP - rem;

	assign sin_v = fold_sine(rem);
	assign cos_v = fold_sine(cos_ang);

endmodule

[rtl/srtc_rotate.sv]
// Products of both endpoints with sine and cosine.
module srtc_rotate
	import srtc_pkg::*;
(
	input  geom_t             geom,
	input  logic signed [8:0] sin_v,
	input  logic signed [8:0] cos_v,
	output prod_t             p0,
	output prod_t             p1
);

	assign p0.xc = 17'(geom.start_px) * 17'(cos_v);
	assign p0.ys = 17'(geom.start_py) * 17'(sin_v);
	assign p0.xs = 17'(geom.start_px) * 17'(sin_v);
	assign p0.yc = 17'(geom.start_py) * 17'(cos_v);
	assign p1.xc = 17'(geom.end_px) * 17'(cos_v);
	assign p1.ys = 17'(geom.end_py) * 17'(sin_v);
	assign p1.xs = 17'(geom.end_px) * 17'(sin_v);
	assign p1.yc = 17'(geom.end_py) * 17'(cos_v);

endmodule

[rtl/srtc_place.sv]
// Scale back by 128, translate with the y flip and clamp to the screen.
module srtc_place
	import srtc_pkg::*;
(
	input  stage4_t    st,
	input  logic [8:0] screen_width,
	input  logic [8:0] screen_height,
	output result_t    res
);

	function automatic logic signed [9:0] div128(input logic signed [17:0] v);
		logic signed [17:0] t;
		// bias negatives so the shift truncates toward zero
		t = v[17] ? v + 18'sd127 : v;
		t = t >>> 7;
		return t[9:0];
	endfunction

	function automatic logic [7:0] clamp(input logic signed [15:0] v, input logic [8:0] size);
		logic [8:0] s;
		logic [7:0] r;
		s = (size == 9'd0) ? 9'd1 : ((size > SCREEN_MAX) ? SCREEN_MAX : size);
		if (v[15])
			r = 8'd0;
		else if (v[14:0] >= {6'd0, s})
			r = 8'(s - 9'd1);
		else
			r = v[7:0];
		return r;
	endfunction

	logic signed [9:0]  rx0, ry0, rx1, ry1;
	logic signed [15:0] sx0, sy0, sx1, sy1;

	assign rx0 = div128(18'(st.p0.xc) + 18'(st.p0.ys));
	assign ry0 = div128(18'(st.p0.yc) - 18'(st.p0.xs));
	assign rx1 = div128(18'(st.p1.xc) + 18'(st.p1.ys));
	assign ry1 = div128(18'(st.p1.yc) - 18'(st.p1.xs));

	assign sx0 = 16'(st.centre_x) + 16'(rx0);
	assign sy0 = 16'(st.centre_y) - 16'(ry0);
	assign sx1 = 16'(st.centre_x) + 16'(rx1);
	assign sy1 = 16'(st.centre_y) - 16'(ry1);

	assign res.screen_x0 = clamp(sx0, screen_width);
	assign res.screen_y0 = clamp(sy0, screen_height);
	assign res.screen_x1 = clamp(sx1, screen_width);
	assign res.screen_y1 = clamp(sy1, screen_height);

endmodule

[rtl/srtc_checker.sv]
// Port-level checks for the segment rotate/translate/clamp top level, bound to it.
module srtc_checker
	import srtc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [2:0] in_flight_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// count items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_flight_q <= 3'd0;
		else if (in_xfer && !out_xfer)
			in_flight_q <= in_flight_q + 3'd1;
		else if (out_xfer && !in_xfer)
			in_flight_q <= in_flight_q - 3'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> in_flight_q != 3'd0)
		else $error("result offered with no item in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= 3'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready && in_flight_q == 3'(PIPE_DEPTH))
		else $error("input stalled while the pipeline had room");

endmodule

bind segment_rotate_translate_clamp_top srtc_checker u_srtc_checker (.*);

[tb/sv/segment_rotate_translate_clamp_top_tb.sv]
// Testbench for segment_rotate_translate_clamp_top: random and directed segments, scoreboard.
module segment_rotate_translate_clamp_top_tb
	import srtc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TURN_DEG  = 360;
	localparam int HALF_DEG  = 180;
	localparam int RIGHT_DEG = 90;
	localparam int LUT_STEP  = 5;
	localparam int LUT_LAST  = 18;
	localparam int FIX_ONE   = 128;
	localparam int SINE128 [0:18] = '{1, 11, 22, 33, 44, 55, 64, 73, 81, 88,
		94, 100, 104, 108, 112, 116, 120, 124, 128};

	localparam int PHASES     = 7;
	localparam int PHASE_ITEMS = 180;
	localparam int LONG_HOLD  = 200;

	typedef struct packed {
		logic signed [14:0] centre_x;
		logic signed [14:0] centre_y;
		logic signed [7:0]  start_px;
		logic signed [7:0]  start_py;
		logic signed [7:0]  end_px;
		logic signed [7:0]  end_py;
		logic signed [14:0] angle_deg;
	} segment_t;

	// Predicts screen coordinates of each accepted segment and checks the results in order.
	class screen_board;
		result_t     pending_coords[$];
		int unsigned width_reg;
		int unsigned height_reg;
		int          errors;
		int          shown;

		function new();
			width_reg  = 128;
			height_reg = 64;
			errors     = 0;
			shown      = 0;
		endfunction

		function void set_screen(logic [CFG_IDX_W-1:0] idx, logic [8:0] value);
			if (idx == REG_SCREEN_WIDTH) begin
				width_reg = value;
			end else begin
				height_reg = value;
			end
		endfunction

		function int table_sine(int a);
			int r;
			int idx;
			bit neg;
			r = a % TURN_DEG;
			if (r < 0)
				r += TURN_DEG;
			neg = r > HALF_DEG;
			if (neg)
				r = TURN_DEG - r;
			if (r > RIGHT_DEG)
				r = HALF_DEG - r;
			idx = r / LUT_STEP;
			if (idx > LUT_LAST)
				idx = LUT_LAST;
			return neg ? -SINE128[idx] : SINE128[idx];
		endfunction

		function logic [7:0] clamp_axis(int v, int unsigned size);
			int lim;
			lim = (size == 0) ? 1 : ((size > 256) ? 256 : int'(size));
			if (v < 0)
				return 8'd0;
			if (v >= lim)
				return 8'(lim - 1);
			return 8'(v);
		endfunction

		function void note_segment(segment_t seg);
			int sn, cs, cx, cy, ax, ay, bx, by;
			result_t e;
			sn = table_sine(int'(seg.angle_deg));
			cs = table_sine(RIGHT_DEG - int'(seg.angle_deg));
			cx = int'(seg.centre_x);
			cy = int'(seg.centre_y);
			ax = int'(seg.start_px);
			ay = int'(seg.start_py);
			bx = int'(seg.end_px);
			by = int'(seg.end_py);
			// y flips between the sprite frame and the screen
			e.screen_x0 = clamp_axis(cx + (ax * cs + ay * sn) / FIX_ONE, width_reg);
			e.screen_y0 = clamp_axis(cy - (-ax * sn + ay * cs) / FIX_ONE, height_reg);
			e.screen_x1 = clamp_axis(cx + (bx * cs + by * sn) / FIX_ONE, width_reg);
			e.screen_y1 = clamp_axis(cy - (-bx * sn + by * cs) / FIX_ONE, height_reg);
			pending_coords.push_back(e);
		endfunction

		function void check_screen(result_t got);
			result_t e;
			bit bad;
			if (pending_coords.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result transfer: x0=%0d y0=%0d x1=%0d y1=%0d",
						got.screen_x0, got.screen_y0, got.screen_x1, got.screen_y1);
				end
				return;
			end
			e = pending_coords.pop_front();
			bad = 0;
			if (got.screen_x0 !== e.screen_x0)
				bad = 1;
			if (got.screen_y0 !== e.screen_y0)
				bad = 1;
			if (got.screen_x1 !== e.screen_x1)
				bad = 1;
			if (got.screen_y1 !== e.screen_y1)
				bad = 1;
			if (bad) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("mismatch x0 y0 x1 y1: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
						e.screen_x0, e.screen_y0, e.screen_x1, e.screen_y1,
						got.screen_x0, got.screen_y0, got.screen_x1, got.screen_y1);
				end
			end
		endfunction

		function int pending();
			return pending_coords.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	screen_board board;
	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold_req;

	segment_rotate_translate_clamp_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic segment_t mk(int cx, int cy, int sx, int sy, int ex, int ey, int ang);
		segment_t s;
		s.centre_x  = 15'(cx);
		s.centre_y  = 15'(cy);
		s.start_px  = 8'(sx);
		s.start_py  = 8'(sy);
		s.end_px    = 8'(ex);
		s.end_py    = 8'(ey);
		s.angle_deg = 15'(ang);
		return s;
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			s.centre_x = 15'($urandom_range(0, 340) - 40);
			s.centre_y = 15'($urandom_range(0, 340) - 40);
		end else if (r < 85) begin
			s.centre_x = 15'($urandom_range(0, 900) - 300);
			s.centre_y = 15'($urandom_range(0, 900) - 300);
		end else begin
			s.centre_x = 15'($urandom());
			s.centre_y = 15'($urandom());
		end
		s.start_px = 8'($urandom());
		s.start_py = 8'($urandom());
		s.end_px   = 8'($urandom());
		s.end_py   = 8'($urandom());
		r = $urandom_range(0, 99);
		if (r < 40)
			s.angle_deg = 15'(LUT_STEP * $urandom_range(0, 72) - TURN_DEG * $urandom_range(0, 2));
		else if (r < 60)
			s.angle_deg = 15'($urandom_range(0, 719) - TURN_DEG);
		else
			s.angle_deg = 15'($urandom());
		return s;
	endfunction

	task automatic send_segment(input segment_t seg);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, seg.angle_deg, seg.end_py, seg.end_px,
			seg.start_py, seg.start_px, seg.centre_y, seg.centre_x};
		do @(posedge clk); while (!s_axis_tready);
		board.note_segment(seg);
	endtask

	task automatic idle_sender();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_screen(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		board.set_screen(idx, value);
	endtask

	task automatic run_directed();
		segment_t dir[$];
		dir.push_back(mk(64, 32, 100, 20, -50, -100, 0));
		dir.push_back(mk(64, 32, 100, 20, -50, -100, 90));
		dir.push_back(mk(64, 32, 100, 20, -50, -100, 180));
		dir.push_back(mk(64, 32, 100, 20, -50, -100, 270));
		dir.push_back(mk(64, 32, 100, 20, -50, -100, 360));
		dir.push_back(mk(64, 32, 100, 20, -50, -100, -90));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 45));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 1));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 89));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 91));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 179));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 181));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, 359));
		dir.push_back(mk(64, 32, 40, 10, 10, 40, -1));
		dir.push_back(mk(64, 32, 127, -128, -128, 127, 16383));
		dir.push_back(mk(64, 32, -128, 127, 127, -128, -16384));
		dir.push_back(mk(-16384, -16384, -128, -128, -128, -128, 0));
		dir.push_back(mk(16383, 16383, 127, 127, 127, 127, 16383));
		dir.push_back(mk(0, 0, -128, 127, 127, -128, 135));
		dir.push_back(mk(127, 63, 0, 0, 0, 0, 225));
		dir.push_back(mk(128, 64, 0, 0, 0, 0, 0));
		dir.push_back(mk(-1, -1, 1, 1, -1, -1, 315));
		foreach (dir[i])
			send_segment(dir[i]);
	endtask

	// result side: check every transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_screen(m_axis_tdata);
	end

	// receiver: random stalls, plus a long hold when requested
	initial begin : rx_side
		int hold;
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
				m_axis_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			gap = (rx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : run_limit
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int phase_w [0:PHASES-1];
		int phase_h [0:PHASES-1];
		board = new();
		phase_w = '{128, 256, 1, 0, 511, 0, 40};
		phase_h = '{64, 256, 1, 0, 300, 0, 200};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		wr_en         = 1'b0;
		wr_index      = REG_SCREEN_WIDTH;
		wr_data       = '0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		rx_hold_req   = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				idle_sender();
				wait_drained();
				repeat (PIPE_DEPTH + 2) @(negedge clk);
				if (p == 5) begin
					phase_w[p] = $urandom_range(2, 255);
					phase_h[p] = $urandom_range(2, 255);
				end
				write_screen(REG_SCREEN_WIDTH, 9'(phase_w[p]));
				write_screen(REG_SCREEN_HEIGHT, 9'(phase_h[p]));
			end
			// one phase runs with no idling at all
			tx_idle_on = (p != 1);
			rx_idle_on = (p != 1);
			if (p == 0)
				run_directed();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 60) begin
					// keep offering while the receiver is held off so the pipe fills
					rx_hold_req = LONG_HOLD;
					tx_idle_on  = 1'b0;
				end
				if (p == 2 && i == 100)
					tx_idle_on = 1'b1;
				if (p == 3 && i == 90) begin
					idle_sender();
					wait_drained();
				end
				send_segment(random_segment());
			end
		end

		idle_sender();
		wait_drained();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
